### rtl/output_register_file_with_hold_timeout_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the output register block
// Shared assertion forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef OUTPUT_REGISTER_FILE_WITH_HOLD_TIMEOUT_TOP_DEFINES_SVH
`define OUTPUT_REGISTER_FILE_WITH_HOLD_TIMEOUT_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define OREG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define OREG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/oreg_pkg.sv
// ---------------------------------------------------------------------------
// Output register block package
// Widths, register indexes, command codes and shared types.
// ---------------------------------------------------------------------------
package oreg_pkg;

   localparam int CMD_W     = 2;
   localparam int REG_W     = 16;
   localparam int VAL_W     = 16;
   localparam int LEVEL_W   = 8;
   localparam int COUNT_W   = 8;
   localparam int ADDR_W    = 5;
   localparam int RELAY_W   = 3;
   localparam int DAC_W     = 9;
   localparam int TICK_W    = 16;
   localparam int CHANNELS  = 4;
   localparam int CH_W      = 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [REG_W-1:0] REG_ADDR        = 16'd1;
   localparam logic [REG_W-1:0] REG_LEVEL_ONE   = 16'd2;
   localparam logic [REG_W-1:0] REG_LEVEL_TWO   = 16'd3;
   localparam logic [REG_W-1:0] REG_LEVEL_THREE = 16'd4;
   localparam logic [REG_W-1:0] REG_RELAY       = 16'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD  = 4'd1;

   localparam logic [CH_W-1:0]   CH_RELAY    = 2'd3;
   localparam logic [VAL_W-1:0]  ADDR_MIN    = 16'd1;
   localparam logic [VAL_W-1:0]  ADDR_MAX    = 16'd31;
   localparam logic [ADDR_W-1:0] ADDR_RESET  = 5'd4;
   localparam logic [TICK_W-1:0] TICKS_RESET = 16'd5000;
   localparam logic [COUNT_W-1:0] HOLD_RESET = 8'd5;

   typedef logic [CHANNELS-1:0][LEVEL_W-1:0] level_array_type;

   // Update request from the decode logic to the channel bank.
   typedef struct packed {
      logic                write_en;
      logic [CH_W-1:0]     channel;
      logic [LEVEL_W-1:0]  value;
      logic                step;
   } bank_ctrl_type;

endpackage

### rtl/oreg_if.sv
// ---------------------------------------------------------------------------
// Output register block channel interfaces
// Request, response and register-write channels with valid/ready.
// ---------------------------------------------------------------------------
interface oreg_req_if;
   logic                           valid;
   logic                           ready;
   logic [oreg_pkg::CMD_W-1:0]     command;
   logic [oreg_pkg::REG_W-1:0]     reg_index;
   logic [oreg_pkg::VAL_W-1:0]     write_value;

   modport source (output valid, command, reg_index, write_value, input ready);
   modport sink   (input valid, command, reg_index, write_value, output ready);
endinterface

interface oreg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [oreg_pkg::LEVEL_W-1:0]   read_value;
   logic                           write_ok;
   logic [oreg_pkg::DAC_W-1:0]     dac_code_one;
   logic [oreg_pkg::DAC_W-1:0]     dac_code_two;
   logic [oreg_pkg::DAC_W-1:0]     dac_code_three;
   logic [oreg_pkg::RELAY_W-1:0]   relay_bits;

   modport source (output valid, read_value, write_ok, dac_code_one, dac_code_two,
                   dac_code_three, relay_bits, input ready);
   modport sink   (input valid, read_value, write_ok, dac_code_one, dac_code_two,
                   dac_code_three, relay_bits, output ready);
endinterface

interface oreg_csr_if;
   logic                             valid;
   logic                             ready;
   logic [oreg_pkg::CSR_IDX_W-1:0]   index;
   logic [oreg_pkg::CSR_DAT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/output_register_file_with_hold_timeout_top.sv
// ---------------------------------------------------------------------------
// Output register block with keep-alive timeout
// Three analog levels and three relay bits behind a small register map.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per transfer: a register read, a register
//   write or a fast tick. rsp_chan returns exactly one result per request,
//   in order, showing the read data, the write status and the drive codes
//   after the request took effect. csr_chan writes the two configuration
//   registers (ticks per second, hold seconds); it is always ready and must
//   only be used while no request is in flight.
//   A transferred request passes through the input register, then through
//   decode and state update into the result register. Throughput is one
//   request per cycle while the receiver does not stall, set by the single
//   decode stage, which reads and updates all channel state in one pass.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; after that req_chan.ready drops
//   until the result is taken. Synchronous reset clears both stages, the
//   levels and countdowns, the tick prescaler, sets the bus address to four
//   and loads the default configuration.
// ---------------------------------------------------------------------------
`include "output_register_file_with_hold_timeout_top_defines.svh"

module output_register_file_with_hold_timeout_top (
   input  logic        clock,
   input  logic        reset,
   oreg_req_if.sink    req_chan,
   oreg_rsp_if.source  rsp_chan,
   oreg_csr_if.sink    csr_chan
);
   import oreg_pkg::*;

   // Configuration registers.
   logic [TICK_W-1:0]  tps_ff;
   logic [COUNT_W-1:0] hold_ff;

   // Input register stage.
   logic               s1_valid_ff;
   cmd_type            s1_cmd_ff;
   logic [REG_W-1:0]   s1_reg_ff;
   logic [VAL_W-1:0]   s1_val_ff;

   // Block state outside the channel bank.
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;

   // Result register.
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rd_ff, rd_in;
   logic               ok_ff, ok_in;

   bank_ctrl_type      ctrl, bank_ctrl;
   level_array_type    levels;
   logic               out_free;
   logic               s1_adv;

   // The result register is free when empty or being drained this cycle. The
   // input stage moves forward only then, so the state that the result shows
   // cannot change while that result waits.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff  <= TICKS_RESET;
         hold_ff <= HOLD_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_TICKS: tps_ff  <= csr_chan.data[TICK_W-1:0];
            CSR_HOLD:  hold_ff <= csr_chan.data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   // The command register starts from the unused code so that the decode
   // never sees an unknown command before the first transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_cmd_ff <= CMD_NONE;
      end else if (req_chan.ready && req_chan.valid) begin
         s1_cmd_ff <= cmd_type'(req_chan.command);
         s1_reg_ff <= req_chan.reg_index;
         s1_val_ff <= req_chan.write_value;
      end
   end

   // Decode of the registered request against the current state.
   always_comb begin
      rd_in   = '0;
      ok_in   = 1'b0;
      ctrl    = '0;
      tick_in = tick_ff;
      addr_in = addr_ff;
      unique case (s1_cmd_ff)
         CMD_READ: begin
            if (s1_reg_ff == REG_ADDR) begin
               rd_in = LEVEL_W'(addr_ff);
            end else if (s1_reg_ff == REG_LEVEL_ONE) begin
               rd_in = levels[0];
            end else if (s1_reg_ff == REG_LEVEL_TWO) begin
               rd_in = levels[1];
            end else if (s1_reg_ff == REG_LEVEL_THREE) begin
               rd_in = levels[2];
            end else if (s1_reg_ff == REG_RELAY) begin
               rd_in = LEVEL_W'(levels[CH_RELAY][RELAY_W-1:0]);
            end
         end
         CMD_WRITE: begin
            if (s1_reg_ff == REG_ADDR) begin
               // Bus address writes outside the legal range are dropped.
               if (s1_val_ff >= ADDR_MIN && s1_val_ff <= ADDR_MAX) begin
                  addr_in = s1_val_ff[ADDR_W-1:0];
                  ok_in   = 1'b1;
               end
            end else if (s1_reg_ff >= REG_LEVEL_ONE && s1_reg_ff <= REG_LEVEL_THREE) begin
               ctrl.write_en = 1'b1;
               ctrl.channel  = CH_W'(s1_reg_ff - REG_LEVEL_ONE);
               ctrl.value    = s1_val_ff[LEVEL_W-1:0];
               ok_in         = 1'b1;
            end else if (s1_reg_ff == REG_RELAY) begin
               ctrl.write_en = 1'b1;
               ctrl.channel  = CH_RELAY;
               ctrl.value    = LEVEL_W'(s1_val_ff[RELAY_W-1:0]);
               ok_in         = 1'b1;
            end
         end
         CMD_TICK: begin
            // The prescaler counts up to and including the terminal count.
            if (tick_ff < tps_ff) begin
               tick_in = tick_ff + TICK_W'(1);
            end else begin
               tick_in   = '0;
               ctrl.step = 1'b1;
            end
         end
         CMD_NONE: begin
         end
      endcase
   end

   assign bank_ctrl = s1_adv ? ctrl : '0;

   oreg_chan_bank u_bank (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (bank_ctrl),
      .hold_seconds (hold_ff),
      .levels       (levels)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         addr_ff <= ADDR_RESET;
      end else if (s1_adv) begin
         tick_ff <= tick_in;
         addr_ff <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rd_ff <= rd_in;
         ok_ff <= ok_in;
      end
   end

   // Drive codes come straight from the level registers, which hold still
   // for as long as a result waits.
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_value     = rd_ff;
   assign rsp_chan.write_ok       = ok_ff;
   assign rsp_chan.dac_code_one   = {levels[0], 1'b0};
   assign rsp_chan.dac_code_two   = {levels[1], 1'b0};
   assign rsp_chan.dac_code_three = {levels[2], 1'b0};
   assign rsp_chan.relay_bits     = levels[CH_RELAY][RELAY_W-1:0];

   `OREG_ASSERT_NEXT(a_stall_freezes_levels, clock, reset, rsp_chan.valid && !rsp_chan.ready, $stable(levels), "levels changed under a waiting result")
   `OREG_ASSERT_IMP(a_read_write_exclusive, clock, reset, rsp_chan.valid, !(rsp_chan.write_ok && rsp_chan.read_value != '0), "result shows both read data and write status")
   `OREG_ASSERT_IMP(a_address_nonzero, clock, reset, 1'b1, addr_ff != '0, "bus address register holds zero")

endmodule

### rtl/oreg_chan_bank.sv
// ---------------------------------------------------------------------------
// Output channel bank
// Levels and hold countdowns of the four output channels.
// ---------------------------------------------------------------------------
module oreg_chan_bank (
   input  logic                             clock,
   input  logic                             reset,
   input  oreg_pkg::bank_ctrl_type          ctrl,
   input  logic [oreg_pkg::COUNT_W-1:0]     hold_seconds,
   output oreg_pkg::level_array_type        levels
);
   import oreg_pkg::*;

   level_array_type                   level_ff, level_in;
   logic [CHANNELS-1:0][COUNT_W-1:0]  count_ff, count_in;

   // A second step counts each live channel down; an expired channel is cleared.
   always_comb begin
      level_in = level_ff;
      count_in = count_ff;
      if (ctrl.write_en) begin
         level_in[ctrl.channel] = ctrl.value;
         count_in[ctrl.channel] = hold_seconds;
      end else if (ctrl.step) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (count_ff[i] != '0) begin
               count_in[i] = count_ff[i] - COUNT_W'(1);
            end else begin
               level_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         count_ff <= '0;
      end else begin
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

   assign levels = level_ff;

endmodule
